@@ rtl/tbc_pkg.sv @@
// Package for the toy byte cipher: configuration struct, register and mode codes,
// and the nibble substitution functions. No dependencies.

package tbc_pkg;

    localparam int unsigned DataW = 8;
    localparam int unsigned KeyW  = 32;
    localparam int unsigned AddrW = 4;

    typedef enum logic [1:0] {
        REG_KEY         = 2'd0,
        REG_CHAIN_MODE  = 2'd1,
        REG_DIRECTION   = 2'd2,
        REG_INIT_VECTOR = 2'd3
    } reg_idx_t;

    typedef enum logic {
        MODE_ECB = 1'b0,
        MODE_CBC = 1'b1
    } chain_mode_t;

    typedef enum logic {
        DIR_ENCRYPT = 1'b0,
        DIR_DECRYPT = 1'b1
    } direction_t;

    typedef struct packed {
        logic [KeyW-1:0]  key;
        chain_mode_t      chain_mode;
        direction_t       direction;
        logic [DataW-1:0] init_vector;
    } cfg_t;

    // x -> (x+1)*7 mod 16; 4-bit arithmetic wraps for free
    function automatic logic [3:0] nib_sub(input logic [3:0] x);
        logic [3:0] t;
        begin
            t = x + 4'd1;
            return 4'(t * 4'd7);
        end
    endfunction

    function automatic logic [7:0] byte_sub(input logic [7:0] b);
        return {nib_sub(b[7:4]), nib_sub(b[3:0])};
    endfunction

    // the substitution has order four, so three passes invert it
    function automatic logic [7:0] byte_inv_sub(input logic [7:0] b);
        return byte_sub(byte_sub(byte_sub(b)));
    endfunction

    function automatic logic [7:0] rot_left2(input logic [7:0] b);
        return {b[5:0], b[7:6]};
    endfunction

    function automatic logic [7:0] rot_right2(input logic [7:0] b);
        return {b[1:0], b[7:2]};
    endfunction

endpackage

@@ rtl/tbc_stream_if.sv @@
// Stream interfaces for the toy byte cipher: input and result channels.
// Depends on nothing; widths match tbc_pkg.

interface tbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tbc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ rtl/tbc_apb_regs.sv @@
// APB configuration registers of the toy byte cipher.
// Depends on tbc_pkg.

module tbc_apb_regs
    import tbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_KEY:         cfg_next.key         = pwdata;
                REG_CHAIN_MODE:  cfg_next.chain_mode  = chain_mode_t'(pwdata[0]);
                REG_DIRECTION:   cfg_next.direction   = direction_t'(pwdata[0]);
                REG_INIT_VECTOR: cfg_next.init_vector = pwdata[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{key: '0, chain_mode: MODE_ECB, direction: DIR_ENCRYPT,
                         init_vector: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (idx)
            REG_KEY:         prdata = cfg_reg.key;
            REG_CHAIN_MODE:  prdata = {31'd0, cfg_reg.chain_mode};
            REG_DIRECTION:   prdata = {31'd0, cfg_reg.direction};
            REG_INIT_VECTOR: prdata = {24'd0, cfg_reg.init_vector};
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/tbc_core.sv @@
// Combinational cipher datapath: chaining xor plus three toy rounds each way.
// Depends on tbc_pkg.

module tbc_core
    import tbc_pkg::*;
(
    input  cfg_t             cfg,
    input  logic [DataW-1:0] data_in,
    input  logic [DataW-1:0] prev,
    output logic [DataW-1:0] result,
    output logic [DataW-1:0] cipher
);

    logic [7:0] k3, k2, k1, k0;
    logic [7:0] e0, e1, e2, e3;
    logic [7:0] d0, d1, d2, d3;
    logic [7:0] plain_in;

    assign {k3, k2, k1, k0} = cfg.key;

    // encrypt: whiten with the top key byte, rotate after the first two rounds
    assign plain_in = (cfg.chain_mode == MODE_CBC) ? (data_in ^ prev) : data_in;
    assign e0 = plain_in ^ k3;
    assign e1 = rot_left2(byte_sub(e0)) ^ k2;
    assign e2 = rot_left2(byte_sub(e1)) ^ k1;
    assign e3 = byte_sub(e2) ^ k0;

    // decrypt: undo the rounds in reverse order
    assign d0 = data_in ^ k0;
    assign d1 = byte_inv_sub(d0) ^ k1;
    assign d2 = byte_inv_sub(rot_right2(d1)) ^ k2;
    assign d3 = byte_inv_sub(rot_right2(d2)) ^ k3;

    always_comb
    begin
        if (cfg.direction == DIR_ENCRYPT)
        begin
            result = e3;
            cipher = e3;
        end
        else
        begin
            result = (cfg.chain_mode == MODE_CBC) ? (d3 ^ prev) : d3;
            cipher = data_in;
        end
    end

endmodule

@@ rtl/toy_byte_cipher_ecb_cbc_top.sv @@
// Top level of the toy byte cipher (codebook / chaining) with APB configuration.
// Depends on tbc_pkg, tbc_stream_if, tbc_apb_regs and tbc_core.
//
// Channel   Kind          Transaction on           Payload
// in_ch     valid/ready   valid && ready           data_byte[7:0], last_byte
// out_ch    valid/ready   valid && ready           out_byte[7:0], out_last
// apb       APB write     psel&penable&pwrite      paddr[3:0] = 4*index, pwdata
//
// Every input transaction yields exactly one result transaction. A byte is held in
// the input register, runs through the cipher rounds and the chaining xor in one
// combinational pass and lands in the result register, which drives the result
// channel; one byte per cycle sustained while the result channel is ready.
// The chaining feedback is the loop through the chain register, which
// is written as each byte moves into the result register.
// Reset clears the configuration, both valid flags and the chain state (chain byte
// zero, message start set). When the result is not taken, the input register holds
// one more byte and then ready drops.

module toy_byte_cipher_ecb_cbc_top
    import tbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    tbc_in_if.sink           in_ch,
    tbc_out_if.source        out_ch
);

    cfg_t cfg;

    // input register stage
    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [DataW-1:0] s1_data_reg;
    logic             s1_last_reg;

    // result register stage
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [DataW-1:0] out_byte_reg;
    logic             out_last_reg;

    // chaining state
    logic [DataW-1:0] chain_reg;
    logic [DataW-1:0] chain_next;
    logic             at_start_reg;
    logic             at_start_next;

    logic             in_take;
    logic             s1_move;
    logic [DataW-1:0] prev;
    logic [DataW-1:0] result;
    logic [DataW-1:0] cipher;

    tbc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Advance the input stage when the result register is empty or being drained.
    assign s1_move     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_move;
    assign in_take     = in_ch.valid && in_ch.ready;

    // The first byte of a message chains from the vector, later ones from the
    // previous ciphertext byte.
    assign prev = at_start_reg ? cfg.init_vector : chain_reg;

    tbc_core u_core (
        .cfg     (cfg),
        .data_in (s1_data_reg),
        .prev    (prev),
        .result  (result),
        .cipher  (cipher)
    );

    always_comb
    begin
        s1_valid_next  = in_take || (s1_valid_reg && !s1_move);
        out_valid_next = s1_move || (out_valid_reg && !out_ch.ready);
        // update the chain in both modes, so a mode change mid-message sees it
        chain_next     = s1_move ? cipher : chain_reg;
        at_start_next  = s1_move ? s1_last_reg : at_start_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
            at_start_reg  <= 1'b1;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
            at_start_reg  <= at_start_next;
        end
    end

    // payload registers: load on transaction, otherwise hold
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg <= in_ch.data_byte;
            s1_last_reg <= in_ch.last_byte;
        end
        if (s1_move)
        begin
            out_byte_reg <= result;
            out_last_reg <= s1_last_reg;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.out_last = out_last_reg;

    // A byte that ends a message makes the next one start from the vector.
    a_msg_start: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> (at_start_reg == out_last_reg))
        else $error("message start flag does not follow the last byte");

    // Encrypting, the chain holds the ciphertext just delivered to the result register.
    a_chain_enc: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && cfg.direction == DIR_ENCRYPT) |=> (chain_reg == out_byte_reg))
        else $error("chain byte differs from encrypted result");

    // Decrypting, the chain holds the ciphertext input of the byte just moved.
    a_chain_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && cfg.direction == DIR_DECRYPT) |=> (chain_reg == $past(s1_data_reg)))
        else $error("chain byte differs from decrypted input");

    // An empty input stage always takes a byte.
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ch.ready)
        else $error("input stalled with empty input register");

endmodule

@@ dv/tbc_cipher_checker.sv @@
// Checker for the toy byte cipher: watches the APB port and both byte channels,
// predicts every result byte and register read-back and compares them with what the block returns.
// Depends on tbc_pkg and the stream interfaces in tbc_stream_if.
`timescale 1ns / 1ps

module tbc_cipher_checker
    import tbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [31:0]      pwdata,
    input  logic [31:0]      prdata,
    input  logic             pready,
    tbc_in_if                in_mon,
    tbc_out_if               out_mon,
    output int unsigned      outstanding,
    output int unsigned      failures
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cipher_result_t;

    cipher_result_t expected_bytes[$];
    int unsigned    mismatch_total;

    // shadow of the configuration and of the chaining state
    logic [31:0] key_r;
    chain_mode_t mode_r;
    direction_t  dir_r;
    logic [7:0]  iv_r;
    logic [7:0]  chain_r;
    logic        msg_start_r;

    // forward nibble map is 7x + 7; its inverse is 7y - 1 (7 * 7 = 1 mod 16)
    function automatic logic [7:0] sub_fwd(input logic [7:0] b);
        return {4'(b[7:4] * 7 + 7), 4'(b[3:0] * 7 + 7)};
    endfunction

    function automatic logic [7:0] sub_inv(input logic [7:0] b);
        return {4'(b[7:4] * 7 + 15), 4'(b[3:0] * 7 + 15)};
    endfunction

    function automatic logic [7:0] rol2(input logic [7:0] b);
        return 8'((b << 2) | (b >> 6));
    endfunction

    function automatic logic [7:0] ror2(input logic [7:0] b);
        return 8'((b >> 2) | (b << 6));
    endfunction

    function automatic logic [7:0] encrypt_byte(input logic [31:0] k, input logic [7:0] p);
        logic [7:0] v;
        v = p ^ k[31:24];
        v = rol2(sub_fwd(v)) ^ k[23:16];
        v = rol2(sub_fwd(v)) ^ k[15:8];
        return sub_fwd(v) ^ k[7:0];
    endfunction

    function automatic logic [7:0] decrypt_byte(input logic [31:0] k, input logic [7:0] c);
        logic [7:0] v;
        v = c ^ k[7:0];
        v = sub_inv(v) ^ k[15:8];
        v = sub_inv(ror2(v)) ^ k[23:16];
        return sub_inv(ror2(v)) ^ k[31:24];
    endfunction

    function automatic logic [31:0] register_value(input reg_idx_t idx);
        case (idx)
            REG_KEY:         return key_r;
            REG_CHAIN_MODE:  return {31'b0, mode_r};
            REG_DIRECTION:   return {31'b0, dir_r};
            default:         return {24'b0, iv_r};
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        mismatch_total++;
        if (mismatch_total <= 10)
            $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [7:0]     prev;
        logic [7:0]     res;
        cipher_result_t want;
        reg_idx_t       idx;
        if (!rst_n)
        begin
            key_r       = '0;
            mode_r      = MODE_ECB;
            dir_r       = DIR_ENCRYPT;
            iv_r        = '0;
            chain_r     = '0;
            msg_start_r = 1'b1;
            expected_bytes.delete();
            outstanding <= 0;
        end
        else
        begin
            idx = reg_idx_t'(paddr[AddrW-1:2]);
            if (psel && penable && pready && pwrite)
            begin
                case (idx)
                    REG_KEY:         key_r  = pwdata;
                    REG_CHAIN_MODE:  mode_r = chain_mode_t'(pwdata[0]);
                    REG_DIRECTION:   dir_r  = direction_t'(pwdata[0]);
                    REG_INIT_VECTOR: iv_r   = pwdata[7:0];
                    default:         ;
                endcase
            end
            if (psel && penable && pready && !pwrite && prdata !== register_value(idx))
                flag_mismatch("register read-back", register_value(idx), prdata);

            if (in_mon.valid && in_mon.ready)
            begin
                prev = msg_start_r ? iv_r : chain_r;
                if (dir_r == DIR_ENCRYPT)
                begin
                    res     = encrypt_byte(key_r, (mode_r == MODE_CBC) ?
                                           (in_mon.data_byte ^ prev) : in_mon.data_byte);
                    chain_r = res;
                end
                else
                begin
                    res = decrypt_byte(key_r, in_mon.data_byte);
                    if (mode_r == MODE_CBC)
                        res ^= prev;
                    chain_r = in_mon.data_byte;
                end
                msg_start_r = in_mon.last_byte;
                expected_bytes.push_back('{data: res, last: in_mon.last_byte});
            end

            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_bytes.size() == 0)
                    flag_mismatch("result with nothing expected", 0,
                                  {23'b0, out_mon.out_last, out_mon.out_byte});
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_mon.out_byte !== want.data)
                        flag_mismatch("out_byte", 32'(want.data), 32'(out_mon.out_byte));
                    if (out_mon.out_last !== want.last)
                        flag_mismatch("out_last", 32'(want.last), 32'(out_mon.out_last));
                end
            end
            outstanding <= expected_bytes.size();
        end
        failures <= mismatch_total;
    end

endmodule

@@ dv/toy_byte_cipher_ecb_cbc_top_tb.sv @@
// Testbench top for the toy byte cipher: clock, reset, APB programming and
// byte stimulus with random idling; the checker beside the block does the comparing.
// Depends on tbc_pkg, tbc_stream_if, the block and tbc_cipher_checker.
`timescale 1ns / 1ps

module toy_byte_cipher_ecb_cbc_top_tb;
    import tbc_pkg::*;

    localparam int unsigned CycleLimit  = 1000000;
    localparam int unsigned DrainCycles = 8;
    localparam int unsigned LongHold    = 300;
    localparam int unsigned PhaseItems  = 100;
    localparam int unsigned Phases      = 10;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;

    int unsigned outstanding;
    int unsigned failures;
    int unsigned cycle_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned settings_used = 0;

    // shared hints from the stimulus to the result sink; they only shape timing
    bit no_idle = 1'b0;
    bit hold_request = 1'b0;

    tbc_in_if  in_ch();
    tbc_out_if out_ch();

    toy_byte_cipher_ecb_cbc_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    tbc_cipher_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .outstanding (outstanding),
        .failures    (failures)
    );

    always #5 clk = ~clk;

    // Watchdog: give up well beyond the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // One APB transfer: setup cycle, then access cycle until pready.
    // Drop psel and idle before returning so that back-to-back calls never clash.
    task automatic apb_access(input bit is_write, input reg_idx_t idx,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= AddrW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Program every register, with junk above the narrow fields, then read all back.
    task automatic program_cipher(input logic [31:0] key, input chain_mode_t mode,
                                  input direction_t dir, input logic [7:0] iv);
        apb_access(1'b1, REG_KEY, key);
        apb_access(1'b1, REG_CHAIN_MODE, {31'($urandom), mode});
        apb_access(1'b1, REG_DIRECTION, {31'($urandom), dir});
        apb_access(1'b1, REG_INIT_VECTOR, {24'($urandom), iv});
        apb_access(1'b0, REG_KEY, '0);
        apb_access(1'b0, REG_CHAIN_MODE, '0);
        apb_access(1'b0, REG_DIRECTION, '0);
        apb_access(1'b0, REG_INIT_VECTOR, '0);
        settings_used++;
    endtask

    // Offer one byte and return at the edge where the transaction happens.
    // With no gap, valid stays high and only the payload advances.
    task automatic send_byte(input logic [7:0] data, input logic last);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= data;
        in_ch.last_byte <= last;
        do @(posedge clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    // Well-formed message: random bytes, last flag on the final one only.
    task automatic send_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_byte(8'($urandom), i == len - 1);
    endtask

    // Stop offering, wait for every expected result, then let the pipe settle.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Result sink: ready bursts broken by random stalls; a long hold-off on request,
    // and ready held high while the stimulus asks for no idling.
    initial
    begin : result_sink
        int unsigned stall;
        out_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LongHold) @(posedge clk);
            end
            else if (no_idle)
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                stall = pick_gap();
                if (stall != 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [31:0] key;
        logic [7:0]  iv;
        chain_mode_t mode;
        direction_t  dir;
        int unsigned count;
        int unsigned len;

        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.last_byte <= 1'b0;

        // Hold reset, then release it on a rising edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero key, codebook, encrypt; the chain state still advances.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        wait_drained();

        // All-ones key, chaining, vector all ones; a message of extremes.
        program_cipher(32'hFFFF_FFFF, MODE_CBC, DIR_ENCRYPT, 8'hFF);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h3C, 1'b1);

        // Switch mode inside a message: the stored chain byte must carry over.
        send_byte(8'h11, 1'b0);
        wait_drained();
        apb_access(1'b1, REG_CHAIN_MODE, {31'b0, MODE_ECB});
        send_byte(8'h22, 1'b0);
        wait_drained();
        apb_access(1'b1, REG_CHAIN_MODE, {31'b0, MODE_CBC});
        send_byte(8'h33, 1'b1);

        // Change the vector inside a message: only the next message sees it.
        send_byte(8'h44, 1'b0);
        wait_drained();
        apb_access(1'b1, REG_INIT_VECTOR, 32'h0000_0000);
        send_byte(8'h55, 1'b1);
        send_byte(8'h66, 1'b1);
        wait_drained();

        // Decrypt, chaining with a random key and then codebook with a zero key.
        program_cipher($urandom, MODE_CBC, DIR_DECRYPT, 8'hA5);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h96, 1'b0);
        send_byte(8'h69, 1'b1);
        wait_drained();
        program_cipher(32'h0000_0000, MODE_ECB, DIR_DECRYPT, 8'h00);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drained();

        // Random phases: fresh settings each time, mostly whole messages,
        // some stray bytes with random last flags.
        for (int unsigned ph = 0; ph < Phases; ph++)
        begin
            key  = (ph == 0) ? 32'h0000_0000 : (ph == 1) ? 32'hFFFF_FFFF : $urandom;
            iv   = (ph == 0) ? 8'hFF : (ph == 1) ? 8'h00 : 8'($urandom);
            mode = chain_mode_t'((ph < 4) ? ph[0] : 1'($urandom));
            dir  = direction_t'((ph < 4) ? ph[1] : 1'($urandom));
            program_cipher(key, mode, dir, iv);

            // Starve the sink for a long stretch so the block fills and stalls input.
            if (ph == 3 || ph == 8)
                hold_request = 1'b1;
            no_idle = (ph == 6);

            count = 0;
            while (count < PhaseItems)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    len = $urandom_range(1, 12);
                    send_message(len);
                end
                else
                begin
                    len = $urandom_range(1, 3);
                    repeat (len) send_byte(8'($urandom), 1'($urandom));
                end
                count += len;
            end
            no_idle = 1'b0;
            wait_drained();
        end

        $display("Sent %0d bytes under %0d register settings: codebook and chaining,",
                 bytes_sent, settings_used);
        $display("both directions, extreme keys and vectors, in %0d cycles.", cycle_count);
        if (failures == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
